/* rtl/core/jg_pkg.sv */
// Shared constants, types and tables for the Jalali to Gregorian date converter.
package jg_pkg;

	localparam int PY_W    = 12;
	localparam int PM_W    = 4;
	localparam int PD_W    = 5;
	localparam int CY_W    = 13;
	localparam int CM_W    = 4;
	localparam int CD_W    = 5;
	localparam int DAYS_W  = 21;
	localparam int DOY_W   = 9;

	localparam logic [PY_W-1:0]   JALALI_EPOCH = 12'd979;
	localparam logic [CY_W-1:0]   GREG_BASE    = 13'd1600;
	localparam logic [DAYS_W-1:0] ERA_DAYS     = 21'd146097;
	localparam logic [17:0]       CENT_DAYS    = 18'd36524;
	localparam logic [15:0]       QUAD_DAYS    = 16'd1461;
	localparam logic [10:0]       YEAR_DAYS    = 11'd365;

	// floor(x/33) = (x * 1986) >> 16 for x below 32768
	localparam logic [22:0] RECIP_33   = 23'd1986;
	// floor(x/1461) = (x * 45934) >> 26 for x below 36525
	localparam logic [30:0] RECIP_1461 = 31'd45934;

	typedef struct packed {
		logic [CY_W-1:0]  year;
		logic [DOY_W-1:0] doy;
		logic             leap;
	} jg_ys_t;

	typedef struct packed {
		logic [CM_W-1:0] month;
		logic [CD_W-1:0] day;
	} jg_md_t;

	// Days in the Jalali year before the first day of month pm.
	function automatic logic [DOY_W-1:0] jg_jmonth_offset(input logic [PM_W-1:0] pm);
		logic [DOY_W-1:0] off;
		case (pm)
			4'd1:    off = 9'd0;
			4'd2:    off = 9'd31;
			4'd3:    off = 9'd62;
			4'd4:    off = 9'd93;
			4'd5:    off = 9'd124;
			4'd6:    off = 9'd155;
			4'd7:    off = 9'd186;
			4'd8:    off = 9'd216;
			4'd9:    off = 9'd246;
			4'd10:   off = 9'd276;
			4'd11:   off = 9'd306;
			4'd12:   off = 9'd336;
			default: off = 9'd0;
		endcase
		return off;
	endfunction

	// First day of year of a Gregorian month (index 0..11), common year.
	function automatic logic [DOY_W-1:0] jg_gmonth_start(input logic [3:0] idx);
		logic [DOY_W-1:0] st;
		case (idx)
			4'd0:    st = 9'd0;
			4'd1:    st = 9'd31;
			4'd2:    st = 9'd59;
			4'd3:    st = 9'd90;
			4'd4:    st = 9'd120;
			4'd5:    st = 9'd151;
			4'd6:    st = 9'd181;
			4'd7:    st = 9'd212;
			4'd8:    st = 9'd243;
			4'd9:    st = 9'd273;
			4'd10:   st = 9'd304;
			4'd11:   st = 9'd334;
			default: st = 9'd0;
		endcase
		return st;
	endfunction

endpackage

/* rtl/core/jg_in_if.sv */
// Input channel carrying one Jalali date per transfer.
interface jg_in_if import jg_pkg::*; ();
	logic            valid;
	logic            ready;
	logic [PY_W-1:0] persian_year;
	logic [PM_W-1:0] persian_month;
	logic [PD_W-1:0] persian_day;

	modport source (output valid, output persian_year, output persian_month,
		output persian_day, input ready);
	modport sink (input valid, input persian_year, input persian_month,
		input persian_day, output ready);
endinterface

/* rtl/core/jg_out_if.sv */
// Output channel carrying one Gregorian date and status per transfer.
interface jg_out_if import jg_pkg::*; ();
	logic            valid;
	logic            ready;
	logic            status;
	logic [CY_W-1:0] civil_year;
	logic [CM_W-1:0] civil_month;
	logic [CD_W-1:0] civil_day;

	modport source (output valid, output status, output civil_year, output civil_month,
		output civil_day, input ready);
	modport sink (input valid, input status, input civil_year, input civil_month,
		input civil_day, output ready);
endinterface

/* rtl/core/jg_day_count.sv */
// Two pipeline stages turning a Jalali date into a day count from 1600-01-01.
module jg_day_count
	import jg_pkg::*;
(
	input  logic              clk,
	input  logic              en,
	input  logic [PY_W-1:0]   py,
	input  logic [PM_W-1:0]   pm,
	input  logic [PD_W-1:0]   pd,
	output logic [DAYS_W-1:0] days
);

	logic [PY_W-1:0]   jy;
	logic [22:0]       q33_prod;
	logic [DOY_W-1:0]  part;

	logic [PY_W-1:0]   jy_s2;
	logic [6:0]        q33_s2;
	logic [DOY_W-1:0]  part_s2;

	logic [PY_W-1:0]   r33;
	logic [5:0]        r33_n;
	logic [3:0]        quarter;
	logic [DAYS_W-1:0] sum;
	logic [DAYS_W-1:0] days_s3;

	// Stage 2: years since epoch, 33-year cycle count, month and day part
	always_comb begin
		jy       = py - JALALI_EPOCH;
		q33_prod = 23'(jy) * RECIP_33;
		part     = jg_jmonth_offset(pm) + 9'(pd) + 9'd78;
	end

	always_ff @(posedge clk) begin
		if (en) begin
			jy_s2   <= jy;
			q33_s2  <= q33_prod[22:16];
			part_s2 <= part;
		end
	end

	// Stage 3: leap days from the 33-year rule, total count
	always_comb begin
		r33     = jy_s2 - 12'(q33_s2) * 12'd33;
		r33_n   = r33[5:0];
		quarter = 4'((7'(r33_n) + 7'd3) >> 2);
		sum     = 21'(jy_s2) * 21'd365 + {11'd0, q33_s2, 3'd0}
			+ 21'(quarter) + 21'(part_s2);
	end

	always_ff @(posedge clk) begin
		if (en) begin
			days_s3 <= sum;
		end
	end

	assign days = days_s3;

endmodule

/* rtl/core/jg_year_split.sv */
// Four pipeline stages splitting a day count into Gregorian year and day of year.
module jg_year_split
	import jg_pkg::*;
(
	input  logic              clk,
	input  logic              en,
	input  logic [DAYS_W-1:0] days,
	output jg_ys_t            ys
);

	// 400-year cycles
	logic [2:0]        q400;
	logic [DAYS_W-1:0] r400;
	logic [17:0]       rem_s4;
	logic [CY_W-1:0]   gy_s4;

	// 100-year cycles
	logic [17:0]       dec;
	logic [1:0]        cq;
	logic [17:0]       rem2;
	logic [15:0]       nrem;
	logic [CY_W-1:0]   ngy;
	logic              nleap;
	logic [15:0]       rem_s5;
	logic [CY_W-1:0]   gy_s5;
	logic              leap_s5;

	// 4-year cycles
	logic [30:0]       q4_prod;
	logic [15:0]       rem_s6;
	logic [4:0]        q4_s6;
	logic [CY_W-1:0]   gy_s6;
	logic              leap_s6;

	// single years
	logic [15:0]       r4_full;
	logic [10:0]       r4;
	logic [10:0]       t;
	logic [1:0]        yq;
	logic [10:0]       tdoy;
	jg_ys_t            ys_n;
	jg_ys_t            ys_s7;

	always_comb begin
		q400 = 3'd0;
		for (int k = 1; k < 8; k++) begin
			q400 = q400 + {2'd0, (days >= DAYS_W'(k) * ERA_DAYS)};
		end
		r400 = days - 21'(q400) * ERA_DAYS;
	end

	always_ff @(posedge clk) begin
		if (en) begin
			rem_s4 <= r400[17:0];
			gy_s4  <= GREG_BASE + 13'(q400) * 13'd400;
		end
	end

	always_comb begin
		dec  = rem_s4 - 18'd1;
		cq   = {1'b0, (dec >= CENT_DAYS)} + {1'b0, (dec >= 18'd73048)}
			+ {1'b0, (dec >= 18'd109572)};
		rem2 = dec - 18'(cq) * CENT_DAYS;
		if (rem_s4 >= 18'd36525) begin
			ngy = gy_s4 + 13'(cq) * 13'd100;
			if (rem2 >= 18'd365) begin
				nrem  = 16'(rem2 + 18'd1);
				nleap = 1'b1;
			end else begin
				nrem  = rem2[15:0];
				nleap = 1'b0;
			end
		end else begin
			ngy   = gy_s4;
			nrem  = rem_s4[15:0];
			nleap = 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			rem_s5  <= nrem;
			gy_s5   <= ngy;
			leap_s5 <= nleap;
		end
	end

	assign q4_prod = 31'(rem_s5) * RECIP_1461;

	always_ff @(posedge clk) begin
		if (en) begin
			rem_s6  <= rem_s5;
			q4_s6   <= q4_prod[30:26];
			gy_s6   <= gy_s5;
			leap_s6 <= leap_s5;
		end
	end

	always_comb begin
		r4_full   = rem_s6 - 16'(q4_s6) * QUAD_DAYS;
		r4        = r4_full[10:0];
		t         = r4 - 11'd1;
		yq        = {1'b0, (t >= YEAR_DAYS)} + {1'b0, (t >= 11'd730)}
			+ {1'b0, (t >= 11'd1095)};
		tdoy      = t - 11'(yq) * YEAR_DAYS;
		ys_n.year = gy_s6 + {6'd0, q4_s6, 2'd0};
		if (r4 >= 11'd366) begin
			ys_n.year = ys_n.year + 13'(yq);
			ys_n.doy  = tdoy[8:0];
			ys_n.leap = 1'b0;
		end else begin
			ys_n.doy  = r4[8:0];
			ys_n.leap = leap_s6;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			ys_s7 <= ys_n;
		end
	end

	assign ys = ys_s7;

endmodule

/* rtl/core/jg_month_walk.sv */
// Month and day of month from a Gregorian day of year.
module jg_month_walk
	import jg_pkg::*;
(
	input  jg_ys_t ys,
	output jg_md_t md
);

	logic [3:0]       idx;
	logic [DOY_W-1:0] st;
	logic [DOY_W-1:0] sel;
	logic [DOY_W-1:0] dd;

	// Count month starts at or below the day; February adds a day in leap years
	always_comb begin
		idx = 4'd0;
		for (int i = 1; i < 12; i++) begin
			st  = jg_gmonth_start(4'(i)) + {8'd0, (ys.leap && i >= 2)};
			idx = idx + {3'd0, (ys.doy >= st)};
		end
		sel      = jg_gmonth_start(idx) + {8'd0, (ys.leap && idx >= 4'd2)};
		dd       = ys.doy - sel + 9'd1;
		md.month = idx + 4'd1;
		md.day   = dd[CD_W-1:0];
	end

endmodule

/* rtl/core/jalali_to_gregorian_date.sv */
// Jalali to Gregorian date converter, top level with pipeline control.
// Throughput: one date per cycle; the whole pipeline holds while the output stalls.
// Output back-pressure is the only throttle: ready is high whenever the output register
// is empty or being drained in the same cycle.
// Reset (arst_n low, asynchronous) clears all valid flags; payload registers keep junk.
module jalali_to_gregorian_date
	import jg_pkg::*;
(
	input  logic     clk,
	input  logic     arst_n,
	jg_in_if.sink    date_in,
	jg_out_if.source date_out
);

	localparam int STAGES = 7;

	// Pipeline advance: every stage moves together when the output register can load
	logic              adv;
	logic              bad_in;

	logic [STAGES-1:0] vld_q;
	logic [STAGES-1:0] bad_q;

	logic [PY_W-1:0]   py_s1;
	logic [PM_W-1:0]   pm_s1;
	logic [PD_W-1:0]   pd_s1;

	logic [DAYS_W-1:0] days;
	jg_ys_t            ys;
	jg_md_t            md;

	logic              out_vld_q;
	logic              status_q;
	logic [CY_W-1:0]   year_q;
	logic [CM_W-1:0]   month_q;
	logic [CD_W-1:0]   day_q;

	assign adv           = !out_vld_q || date_out.ready;
	assign date_in.ready = adv;

	// Flag dates before the epoch, months outside 1..12 and day zero
	assign bad_in = (date_in.persian_year < JALALI_EPOCH)
		|| !(date_in.persian_month inside {[4'd1:4'd12]})
		|| (date_in.persian_day == '0);

	// Valid and invalid-date flags ride alongside the payload stages
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q <= '0;
			bad_q <= '0;
		end else if (adv) begin
			vld_q <= {vld_q[STAGES-2:0], date_in.valid};
			bad_q <= {bad_q[STAGES-2:0], bad_in};
		end
	end

	// Input register: capture the raw date
	always_ff @(posedge clk) begin
		if (adv) begin
			py_s1 <= date_in.persian_year;
			pm_s1 <= date_in.persian_month;
			pd_s1 <= date_in.persian_day;
		end
	end

	// Stages 2-3: Jalali date to day count since 1600-01-01
	jg_day_count u_day_count (
		.clk  (clk),
		.en   (adv),
		.py   (py_s1),
		.pm   (pm_s1),
		.pd   (pd_s1),
		.days (days)
	);

	// Stages 4-7: 400, 100, 4 and 1 year cycles with leap tracking
	jg_year_split u_year_split (
		.clk  (clk),
		.en   (adv),
		.days (days),
		.ys   (ys)
	);

	// Month walk feeds the output register directly
	jg_month_walk u_month_walk (
		.ys (ys),
		.md (md)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_vld_q <= 1'b0;
		end else if (adv) begin
			out_vld_q <= vld_q[STAGES-1];
		end
	end

	// Output register: zero the date fields of an invalid input
	always_ff @(posedge clk) begin
		if (adv) begin
			status_q <= bad_q[STAGES-1];
			year_q   <= bad_q[STAGES-1] ? '0 : ys.year;
			month_q  <= bad_q[STAGES-1] ? '0 : md.month;
			day_q    <= bad_q[STAGES-1] ? '0 : md.day;
		end
	end

	assign date_out.valid       = out_vld_q;
	assign date_out.status      = status_q;
	assign date_out.civil_year  = year_q;
	assign date_out.civil_month = month_q;
	assign date_out.civil_day   = day_q;

	// An invalid date carries all-zero fields
	a_bad_zero: assert property (@(posedge clk) disable iff (!arst_n)
		date_out.valid && date_out.status |->
			date_out.civil_year == '0 && date_out.civil_month == '0
			&& date_out.civil_day == '0)
		else $error("invalid date with nonzero fields");

	// A converted date has a real month and a nonzero day
	a_good_range: assert property (@(posedge clk) disable iff (!arst_n)
		date_out.valid && !date_out.status |->
			date_out.civil_month != '0 && date_out.civil_month <= 4'd12
			&& date_out.civil_day != '0)
		else $error("converted date out of range");

	// A stalled output freezes every stage
	a_stall_hold: assert property (@(posedge clk) disable iff (!arst_n)
		date_out.valid && !date_out.ready |=> $stable(vld_q) && $stable(bad_q))
		else $error("pipeline moved during output stall");

endmodule

/* dv/jalali_to_gregorian_date_test.sv */
`timescale 1ns / 1ps
// Testbench for jalali_to_gregorian_date: random and directed dates, checked against a predictor.
module jalali_to_gregorian_date_test
	import jg_pkg::*;
();

	// Result status codes.
	localparam logic DATE_OK      = 1'b0;
	localparam logic DATE_INVALID = 1'b1;

	// Gregorian month lengths in a common year; February grows by one in a leap year.
	localparam int unsigned GREG_MONTH_LEN [12] = '{31, 28, 31, 30, 31, 30, 31, 31, 30, 31, 30, 31};

	localparam int unsigned ITEMS_PER_PHASE = 330;
	localparam int unsigned DRAIN_CYCLES    = 16;

	typedef struct packed {
		logic            status;
		logic [CY_W-1:0] year;
		logic [CM_W-1:0] month;
		logic [CD_W-1:0] day;
	} greg_date_t;

	// Holds the Gregorian dates still owed by the block, oldest first, and checks results.
	class date_scoreboard;
		greg_date_t  owed_q[$];
		int unsigned mismatches;
		int unsigned converted;
		int unsigned rejected;
		int unsigned checked;

		function new();
			mismatches = 0;
			converted  = 0;
			rejected   = 0;
			checked    = 0;
		endfunction

		// Convert a Jalali date by day count since year 979, then Gregorian cycles.
		function greg_date_t to_gregorian(logic [PY_W-1:0] py, logic [PM_W-1:0] pm,
			logic [PD_W-1:0] pd);
			greg_date_t  g;
			int unsigned jy, jm, jd, dn, gy, mi, mlen;
			bit          leap, found;
			g  = '0;
			jy = py;
			jm = pm;
			jd = pd;
			if (jy < 979 || jm < 1 || jm > 12 || jd < 1) begin
				g.status = DATE_INVALID;
				return g;
			end
			jy = jy - 979;
			// 33-year cycles carry 8 leap years each
			dn = 365 * jy + (jy / 33) * 8 + ((jy % 33) + 3) / 4;
			for (mi = 1; mi < jm; mi++)
				dn += (mi <= 6) ? 31 : 30;
			// shift so that day 0 is 1600-01-01
			dn += jd - 1 + 79;
			gy = 1600 + 400 * (dn / 146097);
			dn = dn % 146097;
			leap = 1'b1;
			if (dn >= 36525) begin
				dn--;
				gy += 100 * (dn / 36524);
				dn = dn % 36524;
				if (dn >= 365)
					dn++;
				else
					leap = 1'b0;
			end
			gy += 4 * (dn / 1461);
			dn = dn % 1461;
			if (dn >= 366) begin
				leap = 1'b0;
				dn--;
				gy += dn / 365;
				dn = dn % 365;
			end
			found = 1'b0;
			mi    = 0;
			while (!found && mi < 12) begin
				mlen = GREG_MONTH_LEN[mi] + ((mi == 1 && leap) ? 1 : 0);
				if (dn < mlen)
					found = 1'b1;
				else begin
					dn -= mlen;
					mi++;
				end
			end
			if (mi > 11)
				mi = 11;
			g.status = DATE_OK;
			g.year   = gy[CY_W-1:0];
			g.month  = 4'(mi + 1);
			g.day    = 5'(dn + 1);
			return g;
		endfunction

		function void note_date(logic [PY_W-1:0] py, logic [PM_W-1:0] pm, logic [PD_W-1:0] pd);
			greg_date_t g;
			g = to_gregorian(py, pm, pd);
			if (g.status == DATE_OK)
				converted++;
			else
				rejected++;
			owed_q.push_back(g);
		endfunction

		function void check_result(greg_date_t got);
			greg_date_t want;
			checked++;
			if (owed_q.size() == 0) begin
				$error("result with no date pending: status %0d %0d-%0d-%0d",
					got.status, got.year, got.month, got.day);
				mismatches++;
				return;
			end
			want = owed_q.pop_front();
			if (got.status !== want.status) begin
				$error("status mismatch: expected %0d, got %0d", want.status, got.status);
				mismatches++;
			end
			if (got.year !== want.year) begin
				$error("civil_year mismatch: expected %0d, got %0d", want.year, got.year);
				mismatches++;
			end
			if (got.month !== want.month) begin
				$error("civil_month mismatch: expected %0d, got %0d", want.month, got.month);
				mismatches++;
			end
			if (got.day !== want.day) begin
				$error("civil_day mismatch: expected %0d, got %0d", want.day, got.day);
				mismatches++;
			end
		endfunction

		function int unsigned pending();
			return owed_q.size();
		endfunction
	endclass

	logic clk;
	logic arst_n;

	jg_in_if  date_in ();
	jg_out_if date_out ();

	jalali_to_gregorian_date u_dut (
		.clk      (clk),
		.arst_n   (arst_n),
		.date_in  (date_in),
		.date_out (date_out)
	);

	date_scoreboard dates;

	// Percent chance per cycle that the sender holds off or the receiver stalls.
	int unsigned sender_idle_pct;
	int unsigned receiver_stall_pct;

	// 20 ns clock, starting low so the first rising edge falls inside reset.
	always begin
		clk = 1'b0;
		#10;
		clk = 1'b1;
		#10;
	end

	// Receiver: drop ready at random according to the current stall rate.
	always @(posedge clk) begin
		if (arst_n)
			date_out.ready <= ($urandom_range(99) >= receiver_stall_pct);
	end

	// Check every result transfer; values are sampled before this edge's updates land.
	always @(posedge clk) begin
		greg_date_t got;
		if (arst_n && date_out.valid && date_out.ready) begin
			got.status = date_out.status;
			got.year   = date_out.civil_year;
			got.month  = date_out.civil_month;
			got.day    = date_out.civil_day;
			dates.check_result(got);
		end
	end

	// Offer one Jalali date, with random hold-off first, and wait for its transfer.
	task automatic send_date(logic [PY_W-1:0] py, logic [PM_W-1:0] pm, logic [PD_W-1:0] pd);
		while ($urandom_range(99) < sender_idle_pct) begin
			date_in.valid <= 1'b0;
			@(posedge clk);
		end
		date_in.valid         <= 1'b1;
		date_in.persian_year  <= py;
		date_in.persian_month <= pm;
		date_in.persian_day   <= pd;
		do
			@(posedge clk);
		while (!date_in.ready);
		dates.note_date(py, pm, pd);
	endtask

	// Hold the sender until every owed result has come back.
	task automatic drain_results();
		date_in.valid <= 1'b0;
		do
			@(posedge clk);
		while (dates.pending() != 0);
	endtask

	// Mostly well-formed dates with random content; the rest is unconstrained noise.
	task automatic send_random_date();
		logic [PY_W-1:0] py;
		logic [PM_W-1:0] pm;
		logic [PD_W-1:0] pd;
		if ($urandom_range(99) < 85) begin
			py = ($urandom_range(1) == 0) ? PY_W'($urandom_range(1500, 1300))
				: PY_W'($urandom_range(4095, 979));
			pm = PM_W'($urandom_range(12, 1));
			pd = PD_W'($urandom_range(31, 1));
		end else begin
			py = PY_W'($urandom);
			pm = PM_W'($urandom);
			pd = PD_W'($urandom);
		end
		send_date(py, pm, pd);
	endtask

	initial begin
		dates                  = new();
		sender_idle_pct        = 0;
		receiver_stall_pct     = 0;
		arst_n                 = 1'b0;
		date_in.valid          = 1'b0;
		date_in.persian_year   = '0;
		date_in.persian_month  = '0;
		date_in.persian_day    = '0;
		date_out.ready         = 1'b0;
		repeat (3) @(posedge clk);
		arst_n <= 1'b1;

		// Directed: field extremes, each invalid case, month ends and rollover.
		send_date(12'd0, 4'd0, 5'd0);
		send_date(12'd4095, 4'd15, 5'd31);
		send_date(12'd978, 4'd12, 5'd29);
		send_date(12'd979, 4'd1, 5'd1);
		send_date(12'd1403, 4'd0, 5'd10);
		send_date(12'd1403, 4'd13, 5'd5);
		send_date(12'd1403, 4'd15, 5'd1);
		send_date(12'd1403, 4'd5, 5'd0);
		send_date(12'd1403, 4'd1, 5'd1);
		send_date(12'd1402, 4'd12, 5'd29);
		send_date(12'd1403, 4'd12, 5'd30);
		send_date(12'd1399, 4'd12, 5'd30);
		send_date(12'd1403, 4'd12, 5'd31);
		send_date(12'd1402, 4'd12, 5'd31);
		send_date(12'd1403, 4'd6, 5'd31);
		send_date(12'd1403, 4'd7, 5'd31);
		send_date(12'd1378, 4'd10, 5'd11);
		send_date(12'd1478, 4'd10, 5'd11);
		send_date(12'd1578, 4'd12, 5'd10);
		send_date(12'd4095, 4'd12, 5'd31);
		send_date(12'd4095, 4'd1, 5'd1);
		send_date(12'd2000, 4'd11, 5'd30);
		send_date(12'd1000, 4'd7, 5'd15);
		drain_results();

		// Random phases: sender rarely idle with receiver often stalled, then the reverse, then no gaps.
		for (int phase = 0; phase < 3; phase++) begin
			case (phase)
				0: begin
					sender_idle_pct    = 9;
					receiver_stall_pct = 54;
				end
				1: begin
					sender_idle_pct    = 54;
					receiver_stall_pct = 9;
				end
				default: begin
					sender_idle_pct    = 0;
					receiver_stall_pct = 0;
				end
			endcase
			for (int n = 0; n < ITEMS_PER_PHASE; n++) begin
				send_random_date();
				// pause mid-phase so the pipeline runs fully empty once under stall
				if (phase == 0 && n == ITEMS_PER_PHASE / 2)
					drain_results();
			end
			drain_results();
		end

		// Let any stray result surface before judging.
		repeat (DRAIN_CYCLES) @(posedge clk);
		if (dates.pending() != 0) begin
			$error("%0d dates never converted", dates.pending());
			dates.mismatches++;
		end

		$display("Covered %0d dates: %0d valid conversions, %0d invalid inputs.",
			dates.converted + dates.rejected, dates.converted, dates.rejected);
		$display("Checked %0d results across three pacing phases, %0d mismatches.",
			dates.checked, dates.mismatches);
		if (dates.mismatches == 0) begin
			$display("SUCCESS");
		end else begin
			$display("FAILURE");
		end
		$finish;
	end

	// Watchdog: far beyond the slowest correct run.
	initial begin
		#2ms;
		$display("FAILURE");
		$finish;
	end

endmodule
